// ----- rtl/core/exp_tnr_pkg.sv -----
package exp_tnr_pkg;

    localparam int MAX_TERMS_DEF = 24;
    localparam int X_W           = 32;
    localparam int R_W           = 64;
    localparam int TC_W          = 5;
    localparam int FRAC_IN       = 28;
    localparam int FRAC_OUT      = 52;
    localparam int PROD_W        = R_W + X_W;                // 96
    localparam int DIV_BITS      = 8;                        // quotient bits per cycle
    localparam int DIV_CYCLES    = 9;
    localparam int DIVD_W        = DIV_BITS * DIV_CYCLES;    // 72
    localparam int RECIP_BITS    = 2 * FRAC_OUT + 1;         // 105
    localparam int CNT_W         = 7;
    localparam int PC_W          = 4;

    localparam logic [TC_W-1:0] TERM_COUNT_RESET = TC_W'(24);
    localparam logic [R_W-1:0]  ONE_Q52          = R_W'(1) << FRAC_OUT;
    localparam logic [R_W-1:0]  STEP_LIMIT       = {R_W{1'b1}} - ONE_Q52;

    // datapath operations
    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_MUL_LO     = 4'd2;
    localparam logic [3:0] OP_MUL_HI     = 4'd3;
    localparam logic [3:0] OP_SUM        = 4'd4;
    localparam logic [3:0] OP_DIV        = 4'd5;
    localparam logic [3:0] OP_UPDATE     = 4'd6;
    localparam logic [3:0] OP_RECIP_INIT = 4'd7;
    localparam logic [3:0] OP_RECIP      = 4'd8;
    localparam logic [3:0] OP_WRITE      = 4'd9;

    // branch conditions
    localparam logic [2:0] C_NEVER       = 3'd0;
    localparam logic [2:0] C_ALWAYS      = 3'd1;
    localparam logic [2:0] C_NO_IN       = 3'd2;
    localparam logic [2:0] C_M_ZERO      = 3'd3;
    localparam logic [2:0] C_POS         = 3'd4;
    localparam logic [2:0] C_CNT_MORE    = 3'd5;
    localparam logic [2:0] C_OUT_BLOCKED = 3'd6;

    // program addresses
    localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] S_TEST   = 4'd1;
    localparam logic [PC_W-1:0] S_MUL_LO = 4'd2;
    localparam logic [PC_W-1:0] S_MUL_HI = 4'd3;
    localparam logic [PC_W-1:0] S_SUM    = 4'd4;
    localparam logic [PC_W-1:0] S_DIV    = 4'd5;
    localparam logic [PC_W-1:0] S_UPDATE = 4'd6;
    localparam logic [PC_W-1:0] S_FINISH = 4'd7;
    localparam logic [PC_W-1:0] S_RECIP  = 4'd8;
    localparam logic [PC_W-1:0] S_OUTPUT = 4'd9;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      hold;
        logic [2:0]      jump;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_blocked;
        logic m_zero;
        logic pos;
        logic cnt_more;
    } status_t;

    function automatic logic cond_true(logic [2:0] c, status_t s);
        logic res;
        unique case (c)
            C_NEVER:       res = 1'b0;
            C_ALWAYS:      res = 1'b1;
            C_NO_IN:       res = !s.in_valid;
            C_M_ZERO:      res = s.m_zero;
            C_POS:         res = s.pos;
            C_CNT_MORE:    res = s.cnt_more;
            C_OUT_BLOCKED: res = s.out_blocked;
            default:       res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/exp_tnr_rom.sv -----
module exp_tnr_rom
    import exp_tnr_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ctrl_t           ctrl
);

    always_comb
    begin
        unique case (pc)
            S_IDLE:   ctrl = '{op: OP_LOAD,       hold: C_NO_IN,       jump: C_NEVER,
                               target: S_IDLE};
            S_TEST:   ctrl = '{op: OP_NOP,        hold: C_NEVER,       jump: C_M_ZERO,
                               target: S_FINISH};
            S_MUL_LO: ctrl = '{op: OP_MUL_LO,     hold: C_NEVER,       jump: C_NEVER,
                               target: S_IDLE};
            S_MUL_HI: ctrl = '{op: OP_MUL_HI,     hold: C_NEVER,       jump: C_NEVER,
                               target: S_IDLE};
            S_SUM:    ctrl = '{op: OP_SUM,        hold: C_NEVER,       jump: C_NEVER,
                               target: S_IDLE};
            S_DIV:    ctrl = '{op: OP_DIV,        hold: C_CNT_MORE,    jump: C_NEVER,
                               target: S_IDLE};
            S_UPDATE: ctrl = '{op: OP_UPDATE,     hold: C_NEVER,       jump: C_ALWAYS,
                               target: S_TEST};
            S_FINISH: ctrl = '{op: OP_RECIP_INIT, hold: C_NEVER,       jump: C_POS,
                               target: S_OUTPUT};
            S_RECIP:  ctrl = '{op: OP_RECIP,      hold: C_CNT_MORE,    jump: C_NEVER,
                               target: S_IDLE};
            S_OUTPUT: ctrl = '{op: OP_WRITE,      hold: C_OUT_BLOCKED, jump: C_ALWAYS,
                               target: S_IDLE};
            default:  ctrl = '{op: OP_NOP,        hold: C_NEVER,       jump: C_ALWAYS,
                               target: S_IDLE};
        endcase
    end

endmodule

// ----- rtl/core/exp_tnr_seq.sv -----
module exp_tnr_seq
    import exp_tnr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    exp_tnr_rom u_rom (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    // hold keeps the step, otherwise branch or fall through
    always_comb
    begin
        priority if (cond_true(ctrl.hold, status))
            pc_next = pc_reg;
        else if (cond_true(ctrl.jump, status))
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= S_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

// ----- rtl/core/exp_tnr_dp.sv -----
module exp_tnr_dp
    import exp_tnr_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_t                 ctrl,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [TC_W-1:0]       cfg_wdata,
    input  logic                  in_valid,
    input  logic signed [X_W-1:0] x_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [R_W-1:0]        exp_value
);

    localparam int M_W = $clog2(MAX_TERMS + 1);
    localparam logic [M_W-1:0] MAX_M = M_W'(MAX_TERMS);

    logic [TC_W-1:0]   term_count_reg;
    logic              neg_reg;
    logic [X_W-1:0]    a_reg;
    logic [M_W-1:0]    m_reg;
    logic [R_W-1:0]    r_reg;
    logic [R_W-1:0]    prod_lo_reg;
    logic [R_W-1:0]    prod_hi_reg;
    logic [DIVD_W-1:0] divd_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [M_W-1:0]    drem_reg;
    logic [R_W-1:0]    rrem_reg;
    logic [R_W-1:0]    recip_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_valid_reg;
    logic [R_W-1:0]    exp_value_reg;

    logic              load_fire;
    logic              write_fire;
    logic [X_W-1:0]    a_next;
    logic [M_W-1:0]    n_sat;
    logic [PROD_W-1:0] prod_sum;
    logic [M_W:0]      drem_next;
    logic [DIV_BITS-1:0] qbits;
    logic [R_W:0]      rrem_sh;
    logic              rbit;
    logic [R_W-1:0]    r_step;

    assign load_fire  = (ctrl.op == OP_LOAD) && in_valid;
    assign write_fire = (ctrl.op == OP_WRITE) && !(out_valid_reg && !out_ready);

    assign a_next = x_value[X_W-1] ? (~x_value + X_W'(1)) : x_value;
    assign n_sat  = (32'(term_count_reg) > MAX_TERMS) ? MAX_M : M_W'(term_count_reg);

    assign prod_sum = {{X_W{1'b0}}, prod_lo_reg} + {prod_hi_reg, {X_W{1'b0}}};

    // eight restoring steps against the small divisor
    always_comb
    begin
        drem_next = {1'b0, drem_reg};
        qbits     = '0;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            drem_next = {drem_next[M_W-1:0], divd_reg[DIVD_W-1-j]};
            if (drem_next >= {1'b0, m_reg})
            begin
                drem_next = drem_next - {1'b0, m_reg};
                qbits[DIV_BITS-1-j] = 1'b1;
            end
        end
    end

    // one restoring step of 2^104 / r, the one bit enters first
    assign rrem_sh = {rrem_reg, (cnt_reg == CNT_W'(RECIP_BITS))};
    assign rbit    = rrem_sh >= {1'b0, r_reg};

    // saturate when 1 + q does not fit
    assign r_step = ((quo_reg[DIVD_W-1:R_W] != '0) || (quo_reg[R_W-1:0] > STEP_LIMIT)) ?
                    {R_W{1'b1}} : ONE_Q52 + quo_reg[R_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                term_count_reg <= cfg_wdata;
            if (write_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (load_fire)
                begin
                    neg_reg <= x_value[X_W-1];
                    a_reg   <= a_next;
                    m_reg   <= n_sat;
                    r_reg   <= ONE_Q52;
                end
            end
            OP_MUL_LO: prod_lo_reg <= R_W'(r_reg[X_W-1:0]) * R_W'(a_reg);
            OP_MUL_HI: prod_hi_reg <= R_W'(r_reg[R_W-1:X_W]) * R_W'(a_reg);
            OP_SUM:
            begin
                divd_reg <= DIVD_W'(prod_sum[PROD_W-1:FRAC_IN]);
                drem_reg <= '0;
                cnt_reg  <= CNT_W'(DIV_CYCLES);
            end
            OP_DIV:
            begin
                divd_reg <= divd_reg << DIV_BITS;
                quo_reg  <= {quo_reg[DIVD_W-DIV_BITS-1:0], qbits};
                drem_reg <= drem_next[M_W-1:0];
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            OP_UPDATE:
            begin
                r_reg <= r_step;
                m_reg <= m_reg - M_W'(1);
            end
            OP_RECIP_INIT:
            begin
                rrem_reg <= '0;
                cnt_reg  <= CNT_W'(RECIP_BITS);
            end
            OP_RECIP:
            begin
                rrem_reg  <= rbit ? R_W'(rrem_sh - {1'b0, r_reg}) : rrem_sh[R_W-1:0];
                recip_reg <= {recip_reg[R_W-2:0], rbit};
                cnt_reg   <= cnt_reg - CNT_W'(1);
            end
            OP_WRITE:
            begin
                if (write_fire)
                    exp_value_reg <= neg_reg ? recip_reg : r_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.in_valid    = in_valid;
    assign status.out_blocked = out_valid_reg && !out_ready;
    assign status.m_zero      = (m_reg == '0);
    assign status.pos         = !neg_reg;
    assign status.cnt_more    = (cnt_reg != CNT_W'(1));

    assign out_valid = out_valid_reg;
    assign exp_value = exp_value_reg;

endmodule

// ----- rtl/core/exp_taylor_nested_reciprocal.sv -----
// e^x for a signed Q3.28 argument, result unsigned Q12.52, by the nested Taylor
// form r = 1 + r*|x|/m for m = n down to 1 (n = term_count, capped at MAX_TERMS),
// with 1/r returned for negative x. A small microcode program steps one shared
// datapath: each term takes two 32x32 partial products, a 96-bit sum, an
// 8-bit-per-cycle divider by m and the update; the reciprocal is found one
// quotient bit per cycle. One item is worked at a time; the next beat is taken
// while the previous result waits in the output register. term_count is written
// through cfg_we/cfg_wdata and resets to 24.
module exp_taylor_nested_reciprocal
    import exp_tnr_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [TC_W-1:0]       cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [X_W-1:0] x_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [R_W-1:0]        exp_value
);

    ctrl_t   ctrl;
    status_t status;

    exp_tnr_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    exp_tnr_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .x_value   (x_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .exp_value (exp_value)
    );

    assign in_ready = (ctrl.op == OP_LOAD);

endmodule

// ----- verif/exp_result_checker.sv -----
`timescale 1ns / 1ps

module exp_result_checker
    import exp_tnr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [TC_W-1:0]       cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic signed [X_W-1:0] x_value,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [R_W-1:0]        exp_value,
    output int                    fail_count,
    output int                    outstanding
);

    logic [TC_W-1:0] terms_shadow;
    logic [R_W-1:0]  exp_queue[$];
    int              result_beats;

    // nested horner form of the taylor series, reciprocal for negative arguments
    function automatic logic [R_W-1:0] exp_nested(logic signed [X_W-1:0] x,
                                                  logic [TC_W-1:0] terms);
        logic [X_W-1:0]        mag;
        logic [PROD_W-1:0]     prod;
        logic [PROD_W-1:0]     quot;
        logic [R_W-1:0]        r;
        logic [RECIP_BITS-1:0] num;
        int                    n;
        mag = x;
        if (x[X_W-1])
            mag = ~mag + 1'b1;
        n = (terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(terms);
        r = ONE_Q52;
        for (int m = n; m > 0; m--)
        begin
            prod = PROD_W'(r) * PROD_W'(mag);
            quot = (prod >> FRAC_IN) / PROD_W'(m);
            if (quot > PROD_W'(STEP_LIMIT))
                r = '1;
            else
                r = ONE_Q52 + quot[R_W-1:0];
        end
        if (x[X_W-1])
        begin
            num = RECIP_BITS'(1) << (2 * FRAC_OUT);
            r = R_W'(num / RECIP_BITS'(r));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [R_W-1:0] want, logic [R_W-1:0] got);
        $display("mismatch at result beat %0d: %s, expected %h, got %h",
                 result_beats, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_shadow <= TERM_COUNT_RESET;
            exp_queue.delete();
            outstanding  <= 0;
            result_beats <= 0;
            fail_count   = 0;
        end
        else
        begin
            if (cfg_we)
                terms_shadow <= cfg_wdata;
            if (in_valid && in_ready)
                exp_queue.push_back(exp_nested(x_value, terms_shadow));
            if (out_valid && out_ready)
            begin
                if (exp_queue.size() == 0)
                    report_mismatch("result with nothing pending", '0, exp_value);
                else if (exp_queue[0] !== exp_value)
                    report_mismatch("wrong exp_value", exp_queue[0], exp_value);
                if (exp_queue.size() != 0)
                    void'(exp_queue.pop_front());
                result_beats <= result_beats + 1;
            end
            // beats still expected after this edge
            outstanding <= int'(exp_queue.size());
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import exp_tnr_pkg::*;

    localparam int PHASE_GAP  = 20;
    localparam int END_CYCLES = 450;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [TC_W-1:0]       cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [X_W-1:0] x_value;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [R_W-1:0]        exp_value;
    logic                  calm = 1'b0;
    int                    fail_count;
    int                    outstanding;

    int phase_terms[PHASES] = '{1, 2, 24, 7, 0, 16, 31, 12, 20, 5};

    exp_taylor_nested_reciprocal dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_value   (x_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .exp_value (exp_value)
    );

    exp_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_value     (x_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .exp_value   (exp_value),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // sink backpressure, off during the calm phase
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 20);

    task automatic send_x(logic [X_W-1:0] x);
        int gap;
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= x;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle(int extra);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_terms(logic [TC_W-1:0] terms);
        wait_idle(PHASE_GAP);
        cfg_we    <= 1'b1;
        cfg_wdata <= terms;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [X_W-1:0] rand_x();
        int             pick;
        logic [X_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            v = $urandom;
        else if (pick < 75)
        begin
            // magnitude up to 1.0
            v = $urandom_range(0, 32'h1000_0000);
            if ($urandom_range(0, 1))
                v = ~v + 1'b1;
        end
        else if (pick < 85)
        begin
            if ($urandom_range(0, 1))
                v = 32'h7FFF_FFFF - $urandom_range(0, 255);
            else
                v = 32'h8000_0000 + $urandom_range(0, 255);
        end
        else
            v = X_W'($urandom_range(0, 31)) << 27;   // multiples of 0.5 over the range
        return v;
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        x_value   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset term count
        send_x(32'h0000_0000);
        send_x(32'h0000_0001);
        send_x(32'hFFFF_FFFF);
        send_x(32'h7FFF_FFFF);
        send_x(32'h8000_0000);   // -8.0, magnitude taken exactly
        send_x(32'h1000_0000);
        send_x(32'hF000_0000);
        send_x(32'h0800_0000);
        send_x(32'hF800_0000);
        send_x(32'h5555_5555);
        send_x(32'hAAAA_AAAA);

        // zero terms gives 1.0 for either sign
        set_terms(5'd0);
        send_x(32'h2000_0000);
        send_x(32'hE000_0000);

        set_terms(5'd1);
        send_x(32'h7FFF_FFFF);
        send_x(32'h8000_0000);

        // above the maximum saturates
        set_terms(5'd31);
        send_x(32'h1000_0000);
        send_x(32'h8000_0000);
        set_terms(5'd25);
        send_x(32'hF000_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                set_terms(TC_W'($urandom_range(0, 31)));
            else
                set_terms(TC_W'(phase_terms[p]));
            calm <= (p == 2);
            for (int i = 0; i < PHASE_LEN; i++)
                send_x(rand_x());
        end

        wait_idle(END_CYCLES);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
